/* rtl/core/cbfm_pkg.sv */
// shared types and constants of the cassette byte fsk modulator
package cbfm_pkg;

  localparam int SYNC_LEN = 8;
  localparam int FILL_W   = $clog2(SYNC_LEN + 1);
  localparam int WIN_IDX_W = $clog2(SYNC_LEN);

  localparam logic [7:0] SYNC_PATTERN [SYNC_LEN] = '{
    8'h1F, 8'hA6, 8'hDE, 8'hBA, 8'hCC, 8'h13, 8'h7D, 8'h74
  };

  // register widths and reset values
  localparam int PERIOD_W = 7;
  localparam int LEN_W    = 14;
  localparam int CFG_W    = 14;
  localparam int CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 7'd16;
  localparam logic [LEN_W-1:0]    PILOT_RST   = 14'd4000;
  localparam logic [LEN_W-1:0]    SILENCE_RST = 14'd1000;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 7'd4;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 7'd64;

  // output field widths
  localparam int HP_W = 6;
  localparam int HC_W = 16;
  localparam int SC_W = 20;

  // bit cells per tape byte: start, eight data, three stop
  localparam int CELLS    = 12;
  localparam int STEP_W   = $clog2(CELLS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD  = 2'd0,
    CFG_PILOT   = 2'd1,
    CFG_SILENCE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEG_SILENCE = 2'd0,
    SEG_WAVE    = 2'd1,
    SEG_ERROR   = 2'd2,
    SEG_EOT     = 2'd3
  } seg_e;

  typedef enum logic [1:0] {
    CMD_ERR  = 2'd0,
    CMD_EOT  = 2'd1,
    CMD_LEAD = 2'd2,
    CMD_BYTE = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    seg_e            segment;
    logic            start_high;
    logic [HP_W-1:0] half_period;
    logic [HC_W-1:0] half_count;
    logic [SC_W-1:0] sample_count;
    logic            cell_bit;
    logic            last;
  } res_t;

  // clamp to 4..64, then clear the low two bits
  function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    logic [PERIOD_W-1:0] c;
    c = p;
    if (p < PERIOD_MIN) c = PERIOD_MIN;
    if (p > PERIOD_MAX) c = PERIOD_MAX;
    return c & ~PERIOD_W'(3);
  endfunction

endpackage

/* rtl/core/cbfm_front.sv */
// front end: sync header window, classification into commands
module cbfm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               kind_i,
  input  logic [7:0]         data_byte_i,
  output logic               push_o,
  output cbfm_pkg::cmd_t     cmd_o
);

  logic [7:0]                  win_q [cbfm_pkg::SYNC_LEN];
  logic [7:0]                  win_d [cbfm_pkg::SYNC_LEN];
  logic [cbfm_pkg::FILL_W-1:0] fill_q, fill_d;
  logic                        synced_q, synced_d;
  logic                        failed_q, failed_d;
  logic                        match_new, match_full;

  always_comb begin
    match_new  = (data_byte_i == cbfm_pkg::SYNC_PATTERN[cbfm_pkg::SYNC_LEN-1]);
    match_full = 1'b1;
    for (int i = 0; i < cbfm_pkg::SYNC_LEN; i++) begin
      if (win_q[i] != cbfm_pkg::SYNC_PATTERN[i]) match_full = 1'b0;
      if (i < cbfm_pkg::SYNC_LEN - 1 && win_q[i] != cbfm_pkg::SYNC_PATTERN[i]) begin
        match_new = 1'b0;
      end
    end
  end

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    synced_d    = synced_q;
    failed_d    = failed_q;
    push_o      = 1'b0;
    cmd_o.op    = cbfm_pkg::CMD_ERR;
    cmd_o.data  = win_q[0];
    if (accept_i) begin
      if (failed_q) begin
        push_o = 1'b1;
      end else if (!synced_q) begin
        if (fill_q != cbfm_pkg::FILL_W'(cbfm_pkg::SYNC_LEN)) begin
          if (kind_i) begin
            // short header
            failed_d = 1'b1;
            push_o   = 1'b1;
          end else begin
            win_d[fill_q[cbfm_pkg::WIN_IDX_W-1:0]] = data_byte_i;
            fill_d = fill_q + 1'b1;
            if (fill_q == cbfm_pkg::FILL_W'(cbfm_pkg::SYNC_LEN - 1) && !match_new) begin
              failed_d = 1'b1;
              push_o   = 1'b1;
            end
          end
        end else begin
          synced_d = 1'b1;
          push_o   = 1'b1;
          if (kind_i) begin
            cmd_o.op = cbfm_pkg::CMD_EOT;
            fill_d   = '0;
          end else begin
            cmd_o.op = cbfm_pkg::CMD_LEAD;
            win_d[0] = data_byte_i;
            fill_d   = cbfm_pkg::FILL_W'(1);
          end
        end
      end else if (kind_i) begin
        push_o = 1'b1;
        if (fill_q == '0) begin
          cmd_o.op = cbfm_pkg::CMD_EOT;
        end else begin
          cmd_o.op = cbfm_pkg::CMD_BYTE;
          for (int i = 0; i < cbfm_pkg::SYNC_LEN - 1; i++) win_d[i] = win_q[i+1];
          fill_d = fill_q - 1'b1;
        end
      end else if (fill_q != cbfm_pkg::FILL_W'(cbfm_pkg::SYNC_LEN)) begin
        win_d[fill_q[cbfm_pkg::WIN_IDX_W-1:0]] = data_byte_i;
        fill_d = fill_q + 1'b1;
      end else if (match_full) begin
        // another header: restart the window with this byte
        push_o   = 1'b1;
        cmd_o.op = cbfm_pkg::CMD_LEAD;
        win_d[0] = data_byte_i;
        fill_d   = cbfm_pkg::FILL_W'(1);
      end else begin
        push_o   = 1'b1;
        cmd_o.op = cbfm_pkg::CMD_BYTE;
        for (int i = 0; i < cbfm_pkg::SYNC_LEN - 1; i++) win_d[i] = win_q[i+1];
        win_d[cbfm_pkg::SYNC_LEN-1] = data_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      synced_q <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      synced_q <= synced_d;
      failed_q <= failed_d;
    end
  end

endmodule

/* rtl/core/cbfm_cmd_queue.sv */
// short command queue between front and back end
module cbfm_cmd_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cbfm_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output cbfm_pkg::cmd_t head_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cbfm_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/core/cbfm_back.sv */
// back end: expands commands into segments, one per cycle while a command waits and the output is not stalled
module cbfm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  cbfm_pkg::cmd_t                  cmd_i,
  output logic                            cmd_pop_o,
  input  logic [cbfm_pkg::PERIOD_W-1:0]   period_i,
  input  logic [cbfm_pkg::LEN_W-1:0]      pilot_i,
  input  logic [cbfm_pkg::LEN_W-1:0]      silence_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output cbfm_pkg::res_t                  res_o
);

  localparam int PROD_W = cbfm_pkg::LEN_W + cbfm_pkg::PERIOD_W;

  logic [cbfm_pkg::STEP_W-1:0]   step_q, step_d;
  logic [cbfm_pkg::STEP_W-1:0]   last_step;
  logic                          out_valid_q, out_valid_d;
  cbfm_pkg::res_t                res_q, res_d;
  logic                          advance, step_last;
  logic [cbfm_pkg::PERIOD_W-1:0] per;
  logic [PROD_W-1:0]             sil_prod, pil_prod;
  logic [cbfm_pkg::CELLS-1:0]    frame;
  logic                          bit_val;

  assign per      = cbfm_pkg::eff_period(period_i);
  assign sil_prod = PROD_W'(silence_i) * PROD_W'(per);
  assign pil_prod = PROD_W'(pilot_i) * PROD_W'(per);
  // start 0, data lsb first, three stop 1s
  assign frame    = {3'b111, cmd_i.data, 1'b0};
  assign bit_val  = frame[step_q];

  always_comb begin
    case (cmd_i.op)
      cbfm_pkg::CMD_LEAD: last_step = cbfm_pkg::STEP_W'(1);
      cbfm_pkg::CMD_BYTE: last_step = cbfm_pkg::STEP_W'(cbfm_pkg::CELLS - 1);
      default:            last_step = '0;
    endcase
  end

  assign step_last = (step_q == last_step);
  assign advance   = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = advance && step_last;

  always_comb begin
    res_d              = '0;
    res_d.segment      = cbfm_pkg::SEG_ERROR;
    res_d.last         = step_last;
    case (cmd_i.op)
      cbfm_pkg::CMD_EOT: begin
        res_d.segment = cbfm_pkg::SEG_EOT;
      end
      cbfm_pkg::CMD_LEAD: begin
        if (step_q == '0) begin
          res_d.segment      = cbfm_pkg::SEG_SILENCE;
          res_d.sample_count = sil_prod[cbfm_pkg::SC_W-1:0];
        end else begin
          res_d.segment      = cbfm_pkg::SEG_WAVE;
          res_d.start_high   = 1'b1;
          res_d.half_period  = {1'b0, per[cbfm_pkg::PERIOD_W-1:2]};
          res_d.half_count   = {pilot_i, 2'b00};
          res_d.sample_count = pil_prod[cbfm_pkg::SC_W-1:0];
        end
      end
      cbfm_pkg::CMD_BYTE: begin
        res_d.segment      = cbfm_pkg::SEG_WAVE;
        res_d.start_high   = 1'b1;
        res_d.cell_bit     = bit_val;
        res_d.sample_count = cbfm_pkg::SC_W'(per);
        if (bit_val) begin
          res_d.half_period = {1'b0, per[cbfm_pkg::PERIOD_W-1:2]};
          res_d.half_count  = cbfm_pkg::HC_W'(4);
        end else begin
          res_d.half_period = per[cbfm_pkg::PERIOD_W-1:1];
          res_d.half_count  = cbfm_pkg::HC_W'(2);
        end
      end
      default: begin
        res_d.segment = cbfm_pkg::SEG_ERROR;
      end
    endcase
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) begin
      step_d      = step_last ? '0 : step_q + 1'b1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/cassette_byte_fsk_modulator.sv */
// top level of the cassette byte fsk modulator
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------------------
//   in       | in_valid_i / in_stall_o     | kind_i, data_byte_i
//   out      | out_valid_o / out_stall_i   | segment_o .. last_o (one segment each)
//   cfg      | cfg_we_i                    | cfg_index_i, cfg_data_i
//
// one segment leaves the back end's output register per cycle unless stalled;
// a data byte gives 12 segments, a header 2, error and end of tape 1 each.
// the front end takes one item per cycle while the command queue has room.
// async active-low reset clears control state; the header window contents
// stay undefined until written and need no clearing pass.
// stalls on the output hold the output register and back up into the queue.
module cassette_byte_fsk_modulator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input transaction
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [7:0]                     data_byte_i,
  // output transaction
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     segment_o,
  output logic                           start_high_o,
  output logic [cbfm_pkg::HP_W-1:0]      half_period_o,
  output logic [cbfm_pkg::HC_W-1:0]      half_count_o,
  output logic [cbfm_pkg::SC_W-1:0]      sample_count_o,
  output logic                           cell_bit_o,
  output logic                           last_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [cbfm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cbfm_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [cbfm_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [cbfm_pkg::LEN_W-1:0]    pilot_q, pilot_d;
  logic [cbfm_pkg::LEN_W-1:0]    silence_q, silence_d;

  logic           in_accept;
  logic           push;
  cbfm_pkg::cmd_t push_cmd;
  logic           q_full, q_valid, q_pop;
  cbfm_pkg::cmd_t q_head;
  cbfm_pkg::res_t res;

  // configuration registers
  always_comb begin
    period_d  = period_q;
    pilot_d   = pilot_q;
    silence_d = silence_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        cbfm_pkg::CFG_PERIOD:  period_d  = cfg_data_i[cbfm_pkg::PERIOD_W-1:0];
        cbfm_pkg::CFG_PILOT:   pilot_d   = cfg_data_i[cbfm_pkg::LEN_W-1:0];
        cbfm_pkg::CFG_SILENCE: silence_d = cfg_data_i[cbfm_pkg::LEN_W-1:0];
        default: ;  // unused index: write is dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= cbfm_pkg::PERIOD_RST;
      pilot_q   <= cbfm_pkg::PILOT_RST;
      silence_q <= cbfm_pkg::SILENCE_RST;
    end else begin
      period_q  <= period_d;
      pilot_q   <= pilot_d;
      silence_q <= silence_d;
    end
  end

  // front end stalls only when the queue is full
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  cbfm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  cbfm_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  cbfm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .period_i    (period_q),
    .pilot_i     (pilot_q),
    .silence_i   (silence_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  // segment fields to ports
  assign segment_o      = res.segment;
  assign start_high_o   = res.start_high;
  assign half_period_o  = res.half_period;
  assign half_count_o   = res.half_count;
  assign sample_count_o = res.sample_count;
  assign cell_bit_o     = res.cell_bit;
  assign last_o         = res.last;

endmodule

/* rtl/core/cbfm_checker.sv */
// port-level checks of the cassette byte fsk modulator and their bind
module cbfm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [1:0]                segment_o,
  input logic                      start_high_o,
  input logic [cbfm_pkg::HP_W-1:0] half_period_o,
  input logic [cbfm_pkg::HC_W-1:0] half_count_o,
  input logic [cbfm_pkg::SC_W-1:0] sample_count_o,
  input logic                      cell_bit_o,
  input logic                      last_o
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segment_o)
      && $stable(sample_count_o) && $stable(half_count_o) && $stable(last_o))
    else $error("output transaction changed while stalled");

  // error and end of tape are single, empty segments
  a_flag_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (segment_o == cbfm_pkg::SEG_ERROR || segment_o == cbfm_pkg::SEG_EOT)
      |-> last_o && sample_count_o == '0 && half_count_o == '0 && half_period_o == '0)
    else $error("error or end of tape segment not empty or not last");

  // square waves start high and have even half cycles
  a_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && segment_o == cbfm_pkg::SEG_WAVE |-> start_high_o && !half_count_o[0])
    else $error("square wave with odd half cycles or low start");

  // silence is never the last segment, since its pilot tone follows, and has no half cycles
  a_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && segment_o == cbfm_pkg::SEG_SILENCE |->
      !last_o && !start_high_o && !cell_bit_o && half_count_o == '0)
    else $error("silence segment malformed");

endmodule

bind cassette_byte_fsk_modulator cbfm_checker u_cbfm_checker (.*);
